>>> hw/rtl/t8rm_pkg.sv
// shared types, opcodes and helpers for the register machine execute core
package t8rm_pkg;

    localparam int NUM_REGS_DEF  = 8;
    localparam int MEM_BYTES_DEF = 64;
    localparam int QUEUE_DEPTH   = 2;

    // opcodes
    localparam logic [3:0] OP_IN    = 4'd0;
    localparam logic [3:0] OP_OUT   = 4'd1;
    localparam logic [3:0] OP_MOV   = 4'd2;
    localparam logic [3:0] OP_ADD   = 4'd3;
    localparam logic [3:0] OP_SUB   = 4'd4;
    localparam logic [3:0] OP_MUL   = 4'd5;
    localparam logic [3:0] OP_DIV   = 4'd6;
    localparam logic [3:0] OP_ROL   = 4'd7;
    localparam logic [3:0] OP_ROR   = 4'd8;
    localparam logic [3:0] OP_SHL   = 4'd9;
    localparam logic [3:0] OP_SHR   = 4'd10;
    localparam logic [3:0] OP_LOAD  = 4'd11;
    localparam logic [3:0] OP_STORE = 4'd12;

    // operand modes
    localparam logic [1:0] MODE_REG = 2'd0;
    localparam logic [1:0] MODE_MEM = 2'd1;

    // error codes
    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_DIV0 = 2'd1;
    localparam logic [1:0] ERR_ADDR = 2'd2;

    // classified operation kinds
    typedef enum logic [3:0] {
        K_NOP   = 4'd0,
        K_IN    = 4'd1,
        K_OUT   = 4'd2,
        K_MOV   = 4'd3,
        K_ADD   = 4'd4,
        K_SUB   = 4'd5,
        K_MUL   = 4'd6,
        K_DIV   = 4'd7,
        K_ROT   = 4'd8,
        K_SHIFT = 4'd9,
        K_LOAD  = 4'd10
    } kind_t;

    // one operand: mode, register and literal
    typedef struct packed {
        logic [1:0] mode;
        logic [2:0] rg;
        logic [7:0] lit;
    } opnd_t;

    // classified instruction passed through the queue
    typedef struct packed {
        kind_t      kind;
        logic       right;     // ror or shr
        logic       wr_a;      // destination is operand a
        opnd_t      a;
        opnd_t      b;
        logic [7:0] in_value;
    } instr_t;

    // operand is read through a register: register mode, or memory through a register
    function automatic logic is_regish(input logic [1:0] mode);
        is_regish = (mode == MODE_REG) || (mode == MODE_MEM);
    endfunction

endpackage

>>> hw/rtl/t8rm_front.sv
// front end: accepts instructions, classifies them and queues them
module t8rm_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [3:0]       opcode,
    input  t8rm_pkg::opnd_t  a_op,
    input  t8rm_pkg::opnd_t  b_op,
    input  logic [7:0]       in_value,
    output logic             q_valid,
    input  logic             q_ready,
    output t8rm_pkg::instr_t q_data
);

    localparam int DEPTH = t8rm_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);

    t8rm_pkg::instr_t cls;
    t8rm_pkg::instr_t mem_reg [DEPTH];
    logic [PW-1:0]    wp_reg, wp_next, rp_reg, rp_next;
    logic [PW:0]      cnt_reg, cnt_next;
    logic             push, pop;

    // classify opcode
    always_comb
    begin
        cls.a        = a_op;
        cls.b        = b_op;
        cls.in_value = in_value;
        cls.right    = 1'b0;
        cls.wr_a     = 1'b0;
        case (opcode)
            t8rm_pkg::OP_IN:
            begin
                cls.kind = t8rm_pkg::K_IN;
                cls.wr_a = 1'b1;
            end
            t8rm_pkg::OP_OUT:   cls.kind = t8rm_pkg::K_OUT;
            t8rm_pkg::OP_MOV,
            t8rm_pkg::OP_STORE: cls.kind = t8rm_pkg::K_MOV;
            t8rm_pkg::OP_ADD:   cls.kind = t8rm_pkg::K_ADD;
            t8rm_pkg::OP_SUB:   cls.kind = t8rm_pkg::K_SUB;
            t8rm_pkg::OP_MUL:   cls.kind = t8rm_pkg::K_MUL;
            t8rm_pkg::OP_DIV:   cls.kind = t8rm_pkg::K_DIV;
            t8rm_pkg::OP_ROL,
            t8rm_pkg::OP_ROR:
            begin
                cls.kind  = t8rm_pkg::K_ROT;
                cls.right = (opcode == t8rm_pkg::OP_ROR);
                cls.wr_a  = 1'b1;
            end
            t8rm_pkg::OP_SHL,
            t8rm_pkg::OP_SHR:
            begin
                cls.kind  = t8rm_pkg::K_SHIFT;
                cls.right = (opcode == t8rm_pkg::OP_SHR);
                cls.wr_a  = 1'b1;
            end
            t8rm_pkg::OP_LOAD:
            begin
                cls.kind = t8rm_pkg::K_LOAD;
                cls.wr_a = 1'b1;
            end
            default:            cls.kind = t8rm_pkg::K_NOP;
        endcase
    end

    assign in_ready = (cnt_reg != (PW+1)'(DEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign q_data   = mem_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    // queue pointers
    always_comb
    begin
        wp_next  = push ? ((wp_reg == PW'(DEPTH-1)) ? '0 : wp_reg + 1'b1) : wp_reg;
        rp_next  = pop ? ((rp_reg == PW'(DEPTH-1)) ? '0 : rp_reg + 1'b1) : rp_reg;
        cnt_next = cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= cls;
        end
    end

endmodule

>>> hw/rtl/t8rm_muldiv.sv
// iterative 8-bit shift-add multiplier and restoring divider
module t8rm_muldiv (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        is_div,
    input  logic [7:0]  x,       // multiplicand or divisor
    input  logic [7:0]  y,       // multiplier or dividend
    output logic        done,
    output logic [15:0] result
);

    logic [15:0] acc_reg, acc_next;
    logic [7:0]  x_reg, x_next, q_reg, q_next;
    logic [8:0]  rem_reg, rem_next, trial;
    logic [3:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next, div_reg, div_next, done_reg, done_next;

    assign trial  = {rem_reg[7:0], q_reg[7]} - {1'b0, x_reg};
    assign done   = done_reg;
    assign result = div_reg ? {8'd0, q_reg} : acc_reg;

    // one bit per cycle
    always_comb
    begin
        acc_next  = acc_reg;
        x_next    = x_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        div_next  = div_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = '0;
            x_next    = x;
            q_next    = y;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
            div_next  = is_div;
        end
        else if (busy_reg)
        begin
            if (div_reg)
            begin
                if (!trial[8])
                begin
                    rem_next = trial;
                    q_next   = {q_reg[6:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[7:0], q_reg[7]};
                    q_next   = {q_reg[6:0], 1'b0};
                end
            end
            else
            begin
                if (q_reg[cnt_reg[2:0]])
                begin
                    acc_next = acc_reg + ({8'd0, x_reg} << cnt_reg[2:0]);
                end
            end
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'd7)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            div_reg  <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            div_reg  <= div_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        x_reg   <= x_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
    end

endmodule

>>> hw/rtl/t8rm_back.sv
// back end: operand fetch, execute, write back and result register
module t8rm_back #(
    parameter int NUM_REGS  = t8rm_pkg::NUM_REGS_DEF,
    parameter int MEM_BYTES = t8rm_pkg::MEM_BYTES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    output logic             q_ready,
    input  t8rm_pkg::instr_t q_data,
    output logic             res_valid,
    input  logic             res_ready,
    output logic [7:0]       res_value,
    output logic             res_out,
    output logic [1:0]       res_err,
    output logic             res_carry,
    output logic             res_zero
);

    localparam int MW = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;
    localparam int RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ADDR  = 6'b000010,
        S_MEM   = 6'b000100,
        S_EXEC  = 6'b001000,
        S_WAIT  = 6'b010000,
        S_WB    = 6'b100000
    } state_t;

    state_t           state_reg, state_next;
    t8rm_pkg::instr_t ins_reg;
    logic [7:0]       regs_reg [NUM_REGS];
    logic [NUM_REGS-1:0] rvld_reg;
    logic [7:0]       mem_reg [MEM_BYTES];
    logic [MEM_BYTES-1:0] mvld_reg;
    logic [7:0]       ma_reg, mb_reg, x_reg, y_reg;
    logic             bad_reg;
    logic [15:0]      raw_reg;
    logic [7:0]       res8;
    logic             carry_reg, zero_reg;
    logic             ov_reg;
    logic [7:0]       ov_value_reg;
    logic             ov_out_reg;
    logic [1:0]       ov_err_reg;
    logic             md_start, md_done;
    logic [15:0]      md_result;
    logic [7:0]       ra, rb;
    logic             a_bad, b_bad;
    logic [7:0]       memx, memy;
    logic [7:0]       mb_addr;
    logic [7:0]       memx_rd_reg, memy_rd_reg;
    logic             amem, bmem;

    t8rm_muldiv u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (md_start),
        .is_div (ins_reg.kind == t8rm_pkg::K_DIV),
        .x      (x_reg),
        .y      (y_reg),
        .done   (md_done),
        .result (md_result)
    );

    assign q_ready   = (state_reg == S_IDLE);
    assign res_valid = ov_reg;
    assign res_value = ov_value_reg;
    assign res_out   = ov_out_reg;
    assign res_err   = ov_err_reg;
    assign res_carry = carry_reg;
    assign res_zero  = zero_reg;

    // register operand reads, unknown index flags a bad address
    always_comb
    begin
        a_bad = 32'(ins_reg.a.rg) >= NUM_REGS;
        b_bad = 32'(ins_reg.b.rg) >= NUM_REGS;
        ra = (a_bad || !rvld_reg[RW'(ins_reg.a.rg)]) ? 8'd0 : regs_reg[RW'(ins_reg.a.rg)];
        rb = (b_bad || !rvld_reg[RW'(ins_reg.b.rg)]) ? 8'd0 : regs_reg[RW'(ins_reg.b.rg)];
    end

    // second memory address: load by literal, otherwise a register value
    assign mb_addr = (ins_reg.kind == t8rm_pkg::K_LOAD &&
                      !t8rm_pkg::is_regish(ins_reg.b.mode)) ? ins_reg.b.lit : rb;

    // which operands come from memory
    always_comb
    begin
        amem = ins_reg.a.mode == t8rm_pkg::MODE_MEM && !a_bad &&
               ins_reg.kind != t8rm_pkg::K_IN && ins_reg.kind != t8rm_pkg::K_LOAD &&
               ins_reg.kind != t8rm_pkg::K_NOP;
        if (ins_reg.kind == t8rm_pkg::K_LOAD)
            bmem = !(t8rm_pkg::is_regish(ins_reg.b.mode) && b_bad);
        else
            bmem = ins_reg.b.mode == t8rm_pkg::MODE_MEM && !b_bad &&
                   ins_reg.kind != t8rm_pkg::K_IN && ins_reg.kind != t8rm_pkg::K_OUT &&
                   ins_reg.kind != t8rm_pkg::K_MOV && ins_reg.kind != t8rm_pkg::K_NOP;
    end

    // memory read port, registered
    always_ff @(posedge clk)
    begin
        if (state_reg == S_ADDR)
        begin
            memx_rd_reg <= mem_reg[MW'(ra)];
            memy_rd_reg <= mem_reg[MW'(mb_addr)];
        end
    end

    // operand values after memory stage
    always_comb
    begin
        memx = 8'd0;
        memy = 8'd0;
        if (32'(ma_reg) < MEM_BYTES && mvld_reg[MW'(ma_reg)])
        begin
            memx = memx_rd_reg;
        end
        if (32'(mb_reg) < MEM_BYTES && mvld_reg[MW'(mb_reg)])
        begin
            memy = memy_rd_reg;
        end
    end

    // 8-bit result: rotate and shift computed here, all other kinds taken from raw_reg
    always_comb
    begin
        logic [3:0] n;
        logic [15:0] t;
        n = 4'd0;
        t = 16'd0;
        res8 = 8'd0;
        case (ins_reg.kind)
            t8rm_pkg::K_ROT:
            begin
                n = {1'b0, ins_reg.right ? 3'(8 - y_reg[2:0]) : y_reg[2:0]};
                t = {x_reg, x_reg} << n;
                res8 = t[15:8];
            end
            t8rm_pkg::K_SHIFT:
            begin
                if (y_reg >= 8'd8)
                    res8 = 8'd0;
                else if (ins_reg.right)
                    res8 = x_reg >> y_reg[2:0];
                else
                    res8 = x_reg << y_reg[2:0];
            end
            default: res8 = raw_reg[7:0];
        endcase
    end

    assign md_start = (state_reg == S_EXEC) &&
        (ins_reg.kind == t8rm_pkg::K_MUL || ins_reg.kind == t8rm_pkg::K_DIV) &&
        (x_reg != 8'd0 || ins_reg.kind == t8rm_pkg::K_MUL);

    // control sequence
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (q_valid) state_next = S_ADDR;
            S_ADDR: state_next = S_MEM;
            S_MEM:  state_next = S_EXEC;
            S_EXEC: state_next = md_start ? S_WAIT : S_WB;
            S_WAIT: if (md_done) state_next = S_WB;
            S_WB:   if (!ov_reg || res_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rvld_reg  <= '0;
            mvld_reg  <= '0;
            carry_reg <= 1'b0;
            zero_reg  <= 1'b0;
            ov_reg    <= 1'b0;
            bad_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ov_reg && res_ready && state_reg != S_WB)
                ov_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        ins_reg <= q_data;
                        bad_reg <= 1'b0;
                    end
                end
                // register reads and address forming
                S_ADDR:
                begin
                    ma_reg <= ra;
                    mb_reg <= mb_addr;
                    x_reg  <= t8rm_pkg::is_regish(ins_reg.a.mode) ? ra : ins_reg.a.lit;
                    y_reg  <= t8rm_pkg::is_regish(ins_reg.b.mode) ? rb : ins_reg.b.lit;
                    if (ins_reg.kind != t8rm_pkg::K_NOP &&
                        ((t8rm_pkg::is_regish(ins_reg.a.mode) && a_bad) ||
                         (t8rm_pkg::is_regish(ins_reg.b.mode) && b_bad &&
                          ins_reg.kind != t8rm_pkg::K_IN && ins_reg.kind != t8rm_pkg::K_OUT)))
                        bad_reg <= 1'b1;
                end
                // memory operand reads
                S_MEM:
                begin
                    if (amem)
                        x_reg <= memx;
                    if (ins_reg.kind == t8rm_pkg::K_LOAD)
                        y_reg <= bmem ? memy : 8'd0;
                    else if (bmem)
                        y_reg <= memy;
                    if ((amem && 32'(ma_reg) >= MEM_BYTES) ||
                        (bmem && 32'(mb_reg) >= MEM_BYTES))
                        bad_reg <= 1'b1;
                end
                // arithmetic and data move results; multiply and divide start the iterative unit
                S_EXEC:
                begin
                    case (ins_reg.kind)
                        t8rm_pkg::K_IN:   raw_reg <= {8'd0, ins_reg.in_value};
                        t8rm_pkg::K_ADD:  raw_reg <= 16'(x_reg) + 16'(y_reg);
                        t8rm_pkg::K_SUB:  raw_reg <= 16'(y_reg) - 16'(x_reg);
                        t8rm_pkg::K_MOV,
                        t8rm_pkg::K_OUT:  raw_reg <= {8'd0, x_reg};
                        t8rm_pkg::K_LOAD: raw_reg <= {8'd0, y_reg};
                        default:          raw_reg <= 16'd0;
                    endcase
                end
                S_WAIT:
                begin
                    if (md_done)
                        raw_reg <= md_result;
                end
                // write back, flags and result
                S_WB:
                begin
                    if (!ov_reg || res_ready)
                    begin
                        logic [7:0]   wa;
                        t8rm_pkg::opnd_t d;
                        logic         dbad, wr;
                        d = ins_reg.wr_a ? ins_reg.a : ins_reg.b;
                        wa = ins_reg.wr_a ? ma_reg : mb_reg;
                        wr = !(ins_reg.kind == t8rm_pkg::K_NOP ||
                               ins_reg.kind == t8rm_pkg::K_OUT);
                        dbad = 1'b0;
                        if (wr)
                        begin
                            if (t8rm_pkg::is_regish(d.mode))
                            begin
                                if (32'(d.rg) >= NUM_REGS)
                                    dbad = 1'b1;
                                else if (d.mode == t8rm_pkg::MODE_REG)
                                begin
                                    regs_reg[RW'(d.rg)] <= res8;
                                    rvld_reg[RW'(d.rg)] <= 1'b1;
                                end
                                else if (32'(wa) < MEM_BYTES)
                                begin
                                    mem_reg[MW'(wa)] <= res8;
                                    mvld_reg[MW'(wa)] <= 1'b1;
                                end
                                else
                                    dbad = 1'b1;
                            end
                            else if (32'(d.lit) < MEM_BYTES)
                            begin
                                mem_reg[MW'(d.lit)] <= res8;
                                mvld_reg[MW'(d.lit)] <= 1'b1;
                            end
                            else
                                dbad = 1'b1;
                        end
                        case (ins_reg.kind)
                            t8rm_pkg::K_ADD, t8rm_pkg::K_MUL, t8rm_pkg::K_DIV:
                            begin
                                if (raw_reg > 16'd255) carry_reg <= 1'b1;
                                else if (raw_reg == 16'd0) zero_reg <= 1'b1;
                            end
                            t8rm_pkg::K_SUB:
                            begin
                                if (raw_reg == 16'd0) zero_reg <= 1'b1;
                            end
                            t8rm_pkg::K_ROT, t8rm_pkg::K_SHIFT:
                            begin
                                if (res8 == 8'd0) zero_reg <= 1'b1;
                            end
                            default: ;
                        endcase
                        ov_reg       <= 1'b1;
                        ov_value_reg <= res8;
                        ov_out_reg   <= (ins_reg.kind == t8rm_pkg::K_OUT);
                        ov_err_reg   <= (bad_reg || dbad) ? t8rm_pkg::ERR_ADDR :
                                        (ins_reg.kind == t8rm_pkg::K_DIV && x_reg == 8'd0) ?
                                        t8rm_pkg::ERR_DIV0 : t8rm_pkg::ERR_NONE;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

>>> hw/rtl/toy_8bit_register_machine_execute_core.sv
// Execute core of a toy 8-bit register machine. One decoded instruction is
// taken per request on s_axis and one result per instruction leaves on
// m_axis. Instructions run one at a time in the back end through address,
// memory read, execute and write back states; MUL and DIV (but not DIV by
// zero) also wait on the bit-serial multiply/divide unit, and write back
// waits while the result register still holds an untaken result. A two-entry
// queue lets the front end take the next instruction while the back end
// works, and a result register holds a result until taken.
module toy_8bit_register_machine_execute_core #(
    parameter int NUM_REGS  = t8rm_pkg::NUM_REGS_DEF,
    parameter int MEM_BYTES = t8rm_pkg::MEM_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // opcode, a_mode, a_reg, a_literal, b_mode, b_reg, b_literal, in_value, pad
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_value, out_valid, error_code, carry_out, zero_out, pad
    output logic [15:0] m_axis_tdata
);

    logic             q_valid, q_ready;
    t8rm_pkg::instr_t q_data;
    t8rm_pkg::opnd_t  a_op, b_op;
    logic [7:0]       rv;
    logic             ro, rc, rz;
    logic [1:0]       re;

    assign a_op = '{mode: s_axis_tdata[5:4], rg: s_axis_tdata[8:6], lit: s_axis_tdata[16:9]};
    assign b_op = '{mode: s_axis_tdata[18:17], rg: s_axis_tdata[21:19],
                    lit: s_axis_tdata[29:22]};

    t8rm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .opcode   (s_axis_tdata[3:0]),
        .a_op     (a_op),
        .b_op     (b_op),
        .in_value (s_axis_tdata[37:30]),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_data   (q_data)
    );

    t8rm_back #(
        .NUM_REGS  (NUM_REGS),
        .MEM_BYTES (MEM_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_data    (q_data),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res_value (rv),
        .res_out   (ro),
        .res_err   (re),
        .res_carry (rc),
        .res_zero  (rz)
    );

    assign m_axis_tdata = {3'd0, rz, rc, re, ro, rv};

`ifndef NO_ASSERTIONS
    // error code never takes the unused value
    a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[10:9] != 2'd3))
        else $error("bad error code");
    // sticky carry never falls
    a_carry_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rc) |-> rc)
        else $error("carry cleared");
    // sticky zero never falls
    a_zero_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rz) |-> rz)
        else $error("zero cleared");
`endif

endmodule

>>> tb/toy_8bit_register_machine_execute_core_test.sv
// testbench for the toy 8-bit register machine execute core
`timescale 1ns / 1ps

module toy_8bit_register_machine_execute_core_test;

    localparam logic [1:0] MODE_LIT  = 2'd2;
    localparam logic [1:0] MODE_LIT3 = 2'd3;
    localparam logic [3:0] OP_NOP    = 4'd15;
    localparam int         N_REGS    = t8rm_pkg::NUM_REGS_DEF;
    localparam int         N_BYTES   = t8rm_pkg::MEM_BYTES_DEF;
    localparam int         MW        = $clog2(N_BYTES);

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;

    toy_8bit_register_machine_execute_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    // machine state mirrored by the predictor
    logic [7:0] mach_regs [N_REGS];
    logic [7:0] mach_mem [N_BYTES];
    logic       mach_cf;
    logic       mach_zf;

    // expected results: out_value, out_valid, error_code, carry, zero
    logic [12:0] pending_results[$];

    int error_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic hold_active = 1'b0;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    initial
    begin
        #20000000;
        $display("FAIL toy_8bit_register_machine_execute_core");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // operand read
    function automatic logic [7:0] opnd_value(input logic [1:0] md, input logic [2:0] r,
                                              input logic [7:0] lit, ref logic bad);
        logic [7:0] addr;
        if (md == t8rm_pkg::MODE_REG)
            return mach_regs[r];
        if (md == t8rm_pkg::MODE_MEM)
        begin
            addr = mach_regs[r];
            if (addr < N_BYTES)
                return mach_mem[addr[MW-1:0]];
            bad = 1'b1;
            return 8'd0;
        end
        return lit;
    endfunction

    // operand write, suppressed on bad address
    function automatic void opnd_store(input logic [1:0] md, input logic [2:0] r,
                                       input logic [7:0] lit, input logic [7:0] v,
                                       ref logic bad);
        logic [7:0] addr;
        if (md == t8rm_pkg::MODE_REG)
        begin
            mach_regs[r] = v;
            return;
        end
        addr = (md == t8rm_pkg::MODE_MEM) ? mach_regs[r] : lit;
        if (addr < N_BYTES)
            mach_mem[addr[MW-1:0]] = v;
        else
            bad = 1'b1;
    endfunction

    // executes one instruction on the mirrored state
    function automatic logic [12:0] execute_instr(input logic [39:0] d);
        logic [3:0]  op;
        logic [1:0]  am, bm;
        logic [2:0]  ar, br;
        logic [7:0]  al, bl, inv, x, y, res, addr;
        logic [3:0]  n;
        logic [15:0] rot;
        logic        bad, div0, vld;
        int          raw;
        op = d[3:0];   am = d[5:4];   ar = d[8:6];   al = d[16:9];
        bm = d[18:17]; br = d[21:19]; bl = d[29:22]; inv = d[37:30];
        bad = 1'b0; div0 = 1'b0; vld = 1'b0; res = 8'd0;
        case (op)
            t8rm_pkg::OP_IN:
            begin
                res = inv;
                opnd_store(am, ar, al, res, bad);
            end
            t8rm_pkg::OP_OUT:
            begin
                res = opnd_value(am, ar, al, bad);
                vld = 1'b1;
            end
            t8rm_pkg::OP_MOV, t8rm_pkg::OP_STORE:
            begin
                res = opnd_value(am, ar, al, bad);
                opnd_store(bm, br, bl, res, bad);
            end
            t8rm_pkg::OP_ADD, t8rm_pkg::OP_SUB, t8rm_pkg::OP_MUL, t8rm_pkg::OP_DIV:
            begin
                x = opnd_value(am, ar, al, bad);
                y = opnd_value(bm, br, bl, bad);
                if (op == t8rm_pkg::OP_ADD)
                    raw = int'(x) + int'(y);
                else if (op == t8rm_pkg::OP_SUB)
                    raw = int'(y) - int'(x);
                else if (op == t8rm_pkg::OP_MUL)
                    raw = int'(x) * int'(y);
                else if (x == 0)
                begin
                    raw = 0;
                    div0 = 1'b1;
                end
                else
                    raw = int'(y) / int'(x);
                if (raw > 255)
                    mach_cf = 1'b1;
                else if (raw == 0)
                    mach_zf = 1'b1;
                res = raw[7:0];
                opnd_store(bm, br, bl, res, bad);
            end
            t8rm_pkg::OP_ROL, t8rm_pkg::OP_ROR, t8rm_pkg::OP_SHL, t8rm_pkg::OP_SHR:
            begin
                x = opnd_value(am, ar, al, bad);
                y = opnd_value(bm, br, bl, bad);
                if (op == t8rm_pkg::OP_ROL || op == t8rm_pkg::OP_ROR)
                begin
                    n = {1'b0, y[2:0]};
                    if (op == t8rm_pkg::OP_ROR)
                        n = (4'd8 - n) & 4'd7;
                    rot = {x, x} << n;
                    res = rot[15:8];
                end
                else if (y >= 8)
                    res = 8'd0;
                else
                    res = (op == t8rm_pkg::OP_SHL) ? (x << y[2:0]) : (x >> y[2:0]);
                if (res == 0)
                    mach_zf = 1'b1;
                opnd_store(am, ar, al, res, bad);
            end
            t8rm_pkg::OP_LOAD:
            begin
                addr = (bm == t8rm_pkg::MODE_REG || bm == t8rm_pkg::MODE_MEM) ?
                       mach_regs[br] : bl;
                if (addr < N_BYTES)
                    res = mach_mem[addr[MW-1:0]];
                else
                begin
                    bad = 1'b1;
                    res = 8'd0;
                end
                opnd_store(am, ar, al, res, bad);
            end
            default:
            begin
            end
        endcase
        return {mach_zf, mach_cf,
                bad ? t8rm_pkg::ERR_ADDR : (div0 ? t8rm_pkg::ERR_DIV0 : t8rm_pkg::ERR_NONE),
                vld, res};
    endfunction

    function automatic logic [39:0] pack_instr(input logic [3:0] op, input logic [1:0] am,
                                               input logic [2:0] ar, input logic [7:0] al,
                                               input logic [1:0] bm, input logic [2:0] br,
                                               input logic [7:0] bl, input logic [7:0] inv);
        return {2'b00, inv, bl, br, bm, al, ar, am, op};
    endfunction

    // sends one request, predicting its result when accepted
    task automatic send_request(input logic [39:0] d);
        logic [12:0] predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = execute_instr(d);
        pending_results = {pending_results, predicted};
    endtask

    // receiver: checks results, stalls at random or while held off
    always @(posedge clk)
    begin
        logic [12:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", int'(m_axis_tdata), 0);
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tdata[7:0] != want[7:0])
                    report_mismatch("out_value", int'(m_axis_tdata[7:0]), int'(want[7:0]));
                if (m_axis_tdata[8] != want[8])
                    report_mismatch("out_valid", int'(m_axis_tdata[8]), int'(want[8]));
                if (m_axis_tdata[10:9] != want[10:9])
                    report_mismatch("error_code", int'(m_axis_tdata[10:9]),
                                    int'(want[10:9]));
                if (m_axis_tdata[11] != want[11])
                    report_mismatch("carry_out", int'(m_axis_tdata[11]), int'(want[11]));
                if (m_axis_tdata[12] != want[12])
                    report_mismatch("zero_out", int'(m_axis_tdata[12]), int'(want[12]));
            end
        end
        if (hold_active)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // random byte that mostly lands inside memory
    function automatic logic [7:0] rand_byte();
        return ($urandom_range(99) < 70) ? 8'($urandom_range(N_BYTES - 1))
                                         : 8'($urandom_range(255));
    endfunction

    function automatic logic [39:0] rand_instr();
        logic [3:0] op;
        op = ($urandom_range(99) < 95) ? 4'($urandom_range(12)) : 4'($urandom_range(15));
        return pack_instr(op, 2'($urandom_range(3)), 3'($urandom_range(7)), rand_byte(),
                          2'($urandom_range(3)), 3'($urandom_range(7)), rand_byte(),
                          8'($urandom_range(255)));
    endfunction

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic test_reset();
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        for (int i = 0; i < N_REGS; i++)
            mach_regs[i] = 8'd0;
        for (int i = 0; i < N_BYTES; i++)
            mach_mem[i] = 8'd0;
        mach_cf = 1'b0;
        mach_zf = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
    endtask

    // extremes, every opcode and the special cases
    task automatic test_directed();
        send_request(pack_instr(t8rm_pkg::OP_IN, t8rm_pkg::MODE_REG, 3'd0, 8'd0,
                                t8rm_pkg::MODE_REG, 3'd0, 8'd0, 8'd255));
        send_request(pack_instr(t8rm_pkg::OP_IN, t8rm_pkg::MODE_REG, 3'd7, 8'd0,
                                t8rm_pkg::MODE_REG, 3'd0, 8'd0, 8'd3));
        send_request(pack_instr(t8rm_pkg::OP_OUT, t8rm_pkg::MODE_REG, 3'd0, 8'd0,
                                t8rm_pkg::MODE_REG, 3'd0, 8'd0, 8'd0));
        // negative subtract, then subtract to zero
        send_request(pack_instr(t8rm_pkg::OP_SUB, MODE_LIT, 3'd0, 8'd200,
                                MODE_LIT, 3'd0, 8'd10, 8'd0));
        send_request(pack_instr(t8rm_pkg::OP_SUB, MODE_LIT3, 3'd0, 8'd5,
                                MODE_LIT, 3'd0, 8'd5, 8'd0));
        // divide by zero and plain divide
        send_request(pack_instr(t8rm_pkg::OP_DIV, MODE_LIT, 3'd0, 8'd0,
                                t8rm_pkg::MODE_REG, 3'd1, 8'd0, 8'd0));
        send_request(pack_instr(t8rm_pkg::OP_DIV, t8rm_pkg::MODE_REG, 3'd7, 8'd0,
                                t8rm_pkg::MODE_REG, 3'd0, 8'd0, 8'd0));
        // add without carry, then carry from multiply
        send_request(pack_instr(t8rm_pkg::OP_ADD, t8rm_pkg::MODE_REG, 3'd0, 8'd0,
                                MODE_LIT, 3'd0, 8'd1, 8'd0));
        send_request(pack_instr(t8rm_pkg::OP_MUL, MODE_LIT, 3'd0, 8'd255,
                                t8rm_pkg::MODE_REG, 3'd0, 8'd0, 8'd0));
        send_request(pack_instr(t8rm_pkg::OP_MOV, MODE_LIT, 3'd0, 8'd170,
                                t8rm_pkg::MODE_REG, 3'd2, 8'd0, 8'd0));
        send_request(pack_instr(t8rm_pkg::OP_ROL, t8rm_pkg::MODE_REG, 3'd2, 8'd0,
                                MODE_LIT, 3'd0, 8'd9, 8'd0));
        send_request(pack_instr(t8rm_pkg::OP_ROR, t8rm_pkg::MODE_REG, 3'd2, 8'd0,
                                MODE_LIT, 3'd0, 8'd3, 8'd0));
        send_request(pack_instr(t8rm_pkg::OP_SHL, t8rm_pkg::MODE_REG, 3'd2, 8'd0,
                                MODE_LIT, 3'd0, 8'd8, 8'd0));
        send_request(pack_instr(t8rm_pkg::OP_IN, t8rm_pkg::MODE_REG, 3'd3, 8'd0,
                                t8rm_pkg::MODE_REG, 3'd0, 8'd0, 8'd129));
        send_request(pack_instr(t8rm_pkg::OP_SHR, t8rm_pkg::MODE_REG, 3'd3, 8'd0,
                                MODE_LIT, 3'd0, 8'd7, 8'd0));
        // store to the last byte and past the end
        send_request(pack_instr(t8rm_pkg::OP_STORE, MODE_LIT, 3'd0, 8'd77,
                                MODE_LIT, 3'd0, 8'd63, 8'd0));
        send_request(pack_instr(t8rm_pkg::OP_STORE, MODE_LIT, 3'd0, 8'd77,
                                MODE_LIT, 3'd0, 8'd64, 8'd0));
        send_request(pack_instr(t8rm_pkg::OP_IN, t8rm_pkg::MODE_REG, 3'd4, 8'd0,
                                t8rm_pkg::MODE_REG, 3'd0, 8'd0, 8'd63));
        // load by register, through register, and by literal
        send_request(pack_instr(t8rm_pkg::OP_LOAD, t8rm_pkg::MODE_REG, 3'd5, 8'd0,
                                t8rm_pkg::MODE_REG, 3'd4, 8'd0, 8'd0));
        send_request(pack_instr(t8rm_pkg::OP_LOAD, t8rm_pkg::MODE_REG, 3'd6, 8'd0,
                                t8rm_pkg::MODE_MEM, 3'd4, 8'd0, 8'd0));
        send_request(pack_instr(t8rm_pkg::OP_LOAD, t8rm_pkg::MODE_MEM, 3'd4, 8'd0,
                                MODE_LIT3, 3'd0, 8'd255, 8'd0));
        // memory read through a register holding a bad address
        send_request(pack_instr(t8rm_pkg::OP_OUT, t8rm_pkg::MODE_MEM, 3'd0, 8'd0,
                                t8rm_pkg::MODE_REG, 3'd0, 8'd0, 8'd0));
        send_request(pack_instr(OP_NOP, t8rm_pkg::MODE_REG, 3'd0, 8'd0,
                                t8rm_pkg::MODE_REG, 3'd0, 8'd0, 8'd0));
        wait_drained();
    endtask

    task automatic test_random(input int count, input int idle_pct, input int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
            send_request(rand_instr());
        wait_drained();
    endtask

    // receiver holds off long while the sender keeps offering
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fork
            begin
                hold_active <= 1'b1;
                repeat (200) @(posedge clk);
                hold_active <= 1'b0;
            end
        join_none
        for (int i = 0; i < 40; i++)
            send_request(rand_instr());
        wait_drained();
    endtask

    initial
    begin
        test_reset();
        test_directed();
        test_random(200, 0, 0);
        test_random(200, 69, 0);
        test_random(200, 0, 69);
        test_random(200, 35, 35);
        test_backpressure();
        if (error_count == 0)
            $display("PASS toy_8bit_register_machine_execute_core");
        else
            $display("FAIL toy_8bit_register_machine_execute_core");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/t8rm_pkg.sv
hw/rtl/t8rm_front.sv
hw/rtl/t8rm_muldiv.sv
hw/rtl/t8rm_back.sv
hw/rtl/toy_8bit_register_machine_execute_core.sv
tb/toy_8bit_register_machine_execute_core_test.sv
